// ===== hw/rtl/radix_fraction_converter_assert.svh =====
// assertion macros for the radix fraction converter
// needs a signal named clock and a signal named reset at the point of use
`ifndef RADIX_FRACTION_CONVERTER_ASSERT_SVH
`define RADIX_FRACTION_CONVERTER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define RFC_ASSERT_NOW(label, cond, conseq, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (conseq)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define RFC_ASSERT_NEXT(label, cond, conseq, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (conseq)) \
      else $error(msg);

`endif

// ===== hw/rtl/rfc_pkg.sv =====
// shared constants and helper functions of the radix fraction converter
// no dependencies
package rfc_pkg;

   localparam int INT_W           = 52;
   localparam int NUM_W           = 48;
   localparam int DEN_W           = 49;
   localparam int BASE_W          = 5;
   localparam int CHAR_W          = 8;
   localparam int DIGIT_W         = 4;
   localparam int MAX_CHARS       = 13;
   localparam int FRACTION_DIGITS = 12;
   localparam int DIGIT_SLOTS     = 64;
   localparam int SLOT_W          = $clog2(DIGIT_SLOTS);
   localparam int CNT_W           = SLOT_W + 1;
   localparam int PROD_W          = NUM_W + BASE_W;
   localparam int BIT_W           = $clog2(INT_W);
   localparam int FDIG_W          = $clog2(FRACTION_DIGITS);
   localparam int MUL_STEPS       = BASE_W;
   localparam int QUO_STEPS       = DIGIT_W;

   localparam logic [CHAR_W-1:0] CHAR_POINT    = 8'h2E;
   localparam logic [CHAR_W-1:0] CHAR_ZERO     = 8'h30;
   localparam logic [CHAR_W-1:0] LETTER_OFFSET = 8'd87;

   // register indexes of the csr port
   localparam logic CSR_SOURCE_BASE = 1'b0;
   localparam logic CSR_TARGET_BASE = 1'b1;

   function automatic logic base_ok(input logic [BASE_W-1:0] b);
      return (b >= 5'd2) && (b <= 5'd16);
   endfunction

   // digit value of a character, 31 when it is no digit at all
   function automatic logic [BASE_W-1:0] digit_value(input logic [CHAR_W-1:0] c);
      logic [BASE_W-1:0] d;
      d = 5'd31;
      if (c >= 8'h30 && c <= 8'h39) d = BASE_W'(c - 8'h30);
      else if (c >= 8'h61 && c <= 8'h66) d = BASE_W'(c - 8'h57);
      else if (c >= 8'h41 && c <= 8'h46) d = BASE_W'(c - 8'h37);
      return d;
   endfunction

   function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
      return (d <= 4'd9) ? (CHAR_ZERO + CHAR_W'(d)) : (LETTER_OFFSET + CHAR_W'(d));
   endfunction

endpackage

// ===== hw/rtl/rfc_ram.sv =====
// generic single-port-write ram with registered read
// no dependencies
module rfc_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/radix_fraction_converter.sv =====
// top level of the radix fraction converter: digit accumulation and emission
// depends on rfc_pkg, rfc_ram and radix_fraction_converter_assert.svh
//
// channel   ports                              handshake
// req       req_in_char, req_end_of_number     start && !busy
// rsp       rsp_out_char, rsp_is_last, ...     rsp_strobe, one cycle, no stall
// csr       csr_index, csr_write_data          csr_write_enable
//
// a point or a rejected char is taken in S_IDLE, an accepted digit runs a 5-step shift-add in S_ACC
// end: bit-serial division of the integer (S_IDIV) and a ram write (S_IWR) per integer digit,
// then a ram read (S_IADDR) and an emit (S_IEMIT) per integer digit, S_POINT for the point,
// and per fraction digit 5 multiply steps, 4 quotient steps and an emit
// synchronous reset, no clearing pass; results cannot be stalled
`include "radix_fraction_converter_assert.svh"
module radix_fraction_converter (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [rfc_pkg::CHAR_W-1:0]  req_in_char,
   input  logic                        req_end_of_number,
   output logic                        rsp_strobe,
   output logic [rfc_pkg::CHAR_W-1:0]  rsp_out_char,
   output logic                        rsp_is_last,
   output logic                        rsp_bad_input,
   input  logic                        csr_write_enable,
   input  logic                        csr_index,
   input  logic [rfc_pkg::BASE_W-1:0]  csr_write_data
);
   import rfc_pkg::*;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_ACC   = 4'd1;
   localparam logic [3:0] S_END   = 4'd2;
   localparam logic [3:0] S_IDIV  = 4'd3;
   localparam logic [3:0] S_IWR   = 4'd4;
   localparam logic [3:0] S_IADDR = 4'd5;
   localparam logic [3:0] S_IEMIT = 4'd6;
   localparam logic [3:0] S_POINT = 4'd7;
   localparam logic [3:0] S_FMUL  = 4'd8;
   localparam logic [3:0] S_FDIV  = 4'd9;
   localparam logic [3:0] S_FEMIT = 4'd10;

   logic [3:0]         state_ff, state_in;
   logic [BASE_W-1:0]  source_base_ff, target_base_ff;
   logic [INT_W-1:0]   int_ff, int_in;
   logic [NUM_W-1:0]   num_ff, num_in;
   logic [DEN_W-1:0]   den_ff, den_in;
   logic [1:0]         point_count_ff, point_count_in;
   logic [3:0]         char_count_ff, char_count_in;
   logic               first_point_ff, first_point_in;
   logic               prev_point_ff, prev_point_in;
   logic               invalid_ff, invalid_in;
   logic               end_ff, end_in;
   logic [BASE_W-1:0]  sb_ff, sb_in;
   logic               frac_sel_ff, frac_sel_in;
   logic [PROD_W-1:0]  acc_ff, acc_in;
   logic [PROD_W-1:0]  mc_ff, mc_in;
   logic [DEN_W-1:0]   dacc_ff, dacc_in;
   logic [DEN_W-1:0]   dmc_ff, dmc_in;
   logic [BASE_W-1:0]  mul_ff, mul_in;
   logic [2:0]         step_ff, step_in;
   logic [DIGIT_W-1:0] rem_ff, rem_in;
   logic [BIT_W-1:0]   bit_ff, bit_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [FDIG_W-1:0]  fdig_ff, fdig_in;
   logic [DIGIT_W-1:0] quo_ff, quo_in;

   logic               accept;
   logic [BASE_W-1:0]  in_digit;
   logic [PROD_W-1:0]  acc_add;
   logic [DEN_W-1:0]   dacc_add;
   logic [BASE_W-1:0]  div_part;
   logic               div_ge;
   logic               quo_ge;
   logic               bad_number;
   logic [CNT_W-1:0]   cnt_next;
   logic               ram_wr_en;
   logic [DIGIT_W-1:0] ram_rd_data;

   assign accept   = start && !busy;
   assign busy     = (state_ff != S_IDLE);
   assign in_digit = digit_value(req_in_char);

   // shift-add step, integer/numerator and denominator side by side
   assign acc_add  = mul_ff[0] ? (acc_ff + mc_ff) : acc_ff;
   assign dacc_add = mul_ff[0] ? (dacc_ff + dmc_ff) : dacc_ff;

   // one bit of the restoring division by the target base
   assign div_part = {rem_ff, int_ff[INT_W-1]};
   assign div_ge   = (div_part >= target_base_ff);
   assign quo_ge   = (acc_ff >= mc_ff);
   assign cnt_next = cnt_ff + CNT_W'(1);

   assign bad_number = invalid_ff || (point_count_ff > 2'd1) || first_point_ff ||
                       prev_point_ff || (char_count_ff == 4'd0) || !base_ok(sb_ff) ||
                       !base_ok(target_base_ff) || (den_ff == '0);

   assign ram_wr_en = (state_ff == S_IWR);

   rfc_ram #(
      .WIDTH (DIGIT_W),
      .DEPTH (DIGIT_SLOTS)
   ) u_digit_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (cnt_ff[SLOT_W-1:0]),
      .wr_data (rem_ff),
      .rd_addr (SLOT_W'(cnt_ff - CNT_W'(1))),
      .rd_data (ram_rd_data)
   );

   // sequencer and result word
   always_comb begin
      state_in       = state_ff;
      int_in         = int_ff;
      num_in         = num_ff;
      den_in         = den_ff;
      point_count_in = point_count_ff;
      char_count_in  = char_count_ff;
      first_point_in = first_point_ff;
      prev_point_in  = prev_point_ff;
      invalid_in     = invalid_ff;
      end_in         = end_ff;
      sb_in          = sb_ff;
      frac_sel_in    = frac_sel_ff;
      acc_in         = acc_ff;
      mc_in          = mc_ff;
      dacc_in        = dacc_ff;
      dmc_in         = dmc_ff;
      mul_in         = mul_ff;
      step_in        = step_ff;
      rem_in         = rem_ff;
      bit_in         = bit_ff;
      cnt_in         = cnt_ff;
      fdig_in        = fdig_ff;
      quo_in         = quo_ff;
      rsp_strobe     = 1'b0;
      rsp_out_char   = '0;
      rsp_is_last    = 1'b0;
      rsp_bad_input  = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               end_in      = req_end_of_number;
               sb_in       = source_base_ff;
               frac_sel_in = (point_count_ff == 2'd1);
               acc_in      = PROD_W'(in_digit[DIGIT_W-1:0]);
               mc_in       = (point_count_ff == 2'd1) ? PROD_W'(num_ff) : PROD_W'(int_ff);
               dacc_in     = '0;
               dmc_in      = den_ff;
               mul_in      = source_base_ff;
               step_in     = '0;
               state_in    = req_end_of_number ? S_END : S_IDLE;
               if (char_count_ff >= 4'(MAX_CHARS)) begin
                  invalid_in = 1'b1;
               end else begin
                  if (req_in_char == CHAR_POINT) begin
                     if (point_count_ff != 2'd3) point_count_in = point_count_ff + 2'd1;
                     if (char_count_ff == 4'd0) first_point_in = 1'b1;
                     prev_point_in = 1'b1;
                  end else begin
                     prev_point_in = 1'b0;
                     if (!base_ok(source_base_ff) || (in_digit >= source_base_ff)) begin
                        invalid_in = 1'b1;
                     end else if (point_count_ff <= 2'd1) begin
                        state_in = S_ACC;
                     end
                  end
                  if (char_count_ff != 4'd15) char_count_in = char_count_ff + 4'd1;
               end
            end
         end

         S_ACC: begin
            acc_in  = acc_add;
            dacc_in = dacc_add;
            mc_in   = {mc_ff[PROD_W-2:0], 1'b0};
            dmc_in  = {dmc_ff[DEN_W-2:0], 1'b0};
            mul_in  = mul_ff >> 1;
            step_in = step_ff + 3'd1;
            if (step_ff == 3'(MUL_STEPS - 1)) begin
               if (frac_sel_ff) begin
                  num_in = acc_add[NUM_W-1:0];
                  den_in = dacc_add;
               end else begin
                  int_in = acc_add[INT_W-1:0];
               end
               state_in = end_ff ? S_END : S_IDLE;
            end
         end

         S_END: begin
            rem_in = '0;
            bit_in = '0;
            cnt_in = '0;
            if (bad_number) begin
               rsp_strobe     = 1'b1;
               rsp_is_last    = 1'b1;
               rsp_bad_input  = 1'b1;
               int_in         = '0;
               num_in         = '0;
               den_in         = DEN_W'(1);
               point_count_in = '0;
               char_count_in  = '0;
               first_point_in = 1'b0;
               prev_point_in  = 1'b0;
               invalid_in     = 1'b0;
               state_in       = S_IDLE;
            end else begin
               state_in = S_IDIV;
            end
         end

         S_IDIV: begin
            rem_in = div_ge ? DIGIT_W'(div_part - target_base_ff) : div_part[DIGIT_W-1:0];
            int_in = {int_ff[INT_W-2:0], div_ge};
            bit_in = bit_ff + BIT_W'(1);
            if (bit_ff == BIT_W'(INT_W - 1)) state_in = S_IWR;
         end

         S_IWR: begin
            cnt_in = cnt_next;
            rem_in = '0;
            bit_in = '0;
            if ((int_ff != '0) && (cnt_next < CNT_W'(DIGIT_SLOTS))) state_in = S_IDIV;
            else state_in = S_IADDR;
         end

         S_IADDR: begin
            cnt_in   = cnt_ff - CNT_W'(1);
            state_in = S_IEMIT;
         end

         S_IEMIT: begin
            rsp_strobe   = 1'b1;
            rsp_out_char = digit_char(ram_rd_data);
            rsp_is_last  = (cnt_ff == '0) && (num_ff == '0);
            if (cnt_ff != '0) begin
               state_in = S_IADDR;
            end else if (num_ff != '0) begin
               state_in = S_POINT;
            end else begin
               int_in         = '0;
               den_in         = DEN_W'(1);
               point_count_in = '0;
               char_count_in  = '0;
               first_point_in = 1'b0;
               prev_point_in  = 1'b0;
               invalid_in     = 1'b0;
               state_in       = S_IDLE;
            end
         end

         S_POINT: begin
            rsp_strobe   = 1'b1;
            rsp_out_char = CHAR_POINT;
            acc_in       = '0;
            mc_in        = PROD_W'(num_ff);
            mul_in       = target_base_ff;
            step_in      = '0;
            fdig_in      = '0;
            state_in     = S_FMUL;
         end

         S_FMUL: begin
            acc_in  = acc_add;
            mc_in   = {mc_ff[PROD_W-2:0], 1'b0};
            mul_in  = mul_ff >> 1;
            step_in = step_ff + 3'd1;
            if (step_ff == 3'(MUL_STEPS - 1)) begin
               mc_in    = PROD_W'(den_ff) << (QUO_STEPS - 1);
               step_in  = '0;
               state_in = S_FDIV;
            end
         end

         S_FDIV: begin
            if (quo_ge) acc_in = acc_ff - mc_ff;
            quo_in  = {quo_ff[DIGIT_W-2:0], quo_ge};
            mc_in   = mc_ff >> 1;
            step_in = step_ff + 3'd1;
            if (step_ff == 3'(QUO_STEPS - 1)) state_in = S_FEMIT;
         end

         S_FEMIT: begin
            rsp_strobe   = 1'b1;
            rsp_out_char = digit_char(quo_ff);
            rsp_is_last  = (fdig_ff == FDIG_W'(FRACTION_DIGITS - 1));
            num_in       = acc_ff[NUM_W-1:0];
            fdig_in      = fdig_ff + FDIG_W'(1);
            acc_in       = '0;
            mc_in        = PROD_W'(acc_ff[NUM_W-1:0]);
            mul_in       = target_base_ff;
            step_in      = '0;
            if (fdig_ff == FDIG_W'(FRACTION_DIGITS - 1)) begin
               int_in         = '0;
               num_in         = '0;
               den_in         = DEN_W'(1);
               point_count_in = '0;
               char_count_in  = '0;
               first_point_in = 1'b0;
               prev_point_in  = 1'b0;
               invalid_in     = 1'b0;
               state_in       = S_IDLE;
            end else begin
               state_in = S_FMUL;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state and number state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         source_base_ff <= 5'd10;
         target_base_ff <= 5'd2;
         int_ff         <= '0;
         num_ff         <= '0;
         den_ff         <= DEN_W'(1);
         point_count_ff <= '0;
         char_count_ff  <= '0;
         first_point_ff <= 1'b0;
         prev_point_ff  <= 1'b0;
         invalid_ff     <= 1'b0;
      end else begin
         state_ff       <= state_in;
         int_ff         <= int_in;
         num_ff         <= num_in;
         den_ff         <= den_in;
         point_count_ff <= point_count_in;
         char_count_ff  <= char_count_in;
         first_point_ff <= first_point_in;
         prev_point_ff  <= prev_point_in;
         invalid_ff     <= invalid_in;
         if (csr_write_enable && (csr_index == CSR_SOURCE_BASE)) source_base_ff <= csr_write_data;
         if (csr_write_enable && (csr_index == CSR_TARGET_BASE)) target_base_ff <= csr_write_data;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      end_ff      <= end_in;
      sb_ff       <= sb_in;
      frac_sel_ff <= frac_sel_in;
      acc_ff      <= acc_in;
      mc_ff       <= mc_in;
      dacc_ff     <= dacc_in;
      dmc_ff      <= dmc_in;
      mul_ff      <= mul_in;
      step_ff     <= step_in;
      rem_ff      <= rem_in;
      bit_ff      <= bit_in;
      cnt_ff      <= cnt_in;
      fdig_ff     <= fdig_in;
      quo_ff      <= quo_in;
   end

   // checks
   `RFC_ASSERT_NOW(a_strobe_busy, rsp_strobe, busy, "result word outside a conversion")
   `RFC_ASSERT_NOW(a_bad_word, rsp_strobe && rsp_bad_input, rsp_is_last && (rsp_out_char == '0), "bad-input word malformed")
   `RFC_ASSERT_NEXT(a_last_idle, rsp_strobe && rsp_is_last, !busy && (char_count_ff == 4'd0), "no idle after last word")
   `RFC_ASSERT_NOW(a_frac_below, (state_ff == S_FEMIT), (quo_ff < target_base_ff), "fraction digit not below base")

endmodule
